FILE: design/qwe_pkg.sv
package qwe_pkg;

    localparam int COUNT_WIDTH_DEF    = 16;
    localparam int RATE_FRAC_BITS_DEF = 16;

    localparam logic [15:0] WIN_LEN_RESET = 16'd1024;

    localparam logic [2:0] CODE_MATCH   = 3'd0;
    localparam logic [2:0] CODE_ERROR   = 3'd1;
    localparam logic [2:0] CODE_DOUBLE  = 3'd2;
    localparam logic [2:0] CODE_NOCLICK = 3'd3;
    localparam logic [2:0] CODE_CONTROL = 3'd5;

    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 136;
    localparam int REPORT_LO = 3;
    localparam int REPORT_HI = 130;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_sel_diff;
        logic cap_same;
        logic cap_diff;
        logic load_report;
    } ctrl_cmd_t;

    typedef struct packed {
        logic close;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

FILE: design/qwe_divider.sv
module qwe_divider #(
    parameter int COUNT_WIDTH    = qwe_pkg::COUNT_WIDTH_DEF,
    parameter int RATE_FRAC_BITS = qwe_pkg::RATE_FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [COUNT_WIDTH-1:0] bits,
    input  logic [COUNT_WIDTH-1:0] hits,
    output logic                   done,
    output logic [15:0]            rate
);
    import qwe_pkg::*;

    localparam int CNT_W = $clog2(RATE_FRAC_BITS + 1);

    logic [COUNT_WIDTH-1:0]    rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0]    bits_reg;
    logic [RATE_FRAC_BITS-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      run_reg;
    logic                      done_reg;
    logic                      zero_reg;
    logic                      sat_reg;
    logic [COUNT_WIDTH-1:0]    errs;
    logic [COUNT_WIDTH:0]      rem_shift;
    logic                      fits;
    logic [RATE_FRAC_BITS-1:0] result;

    assign errs      = (hits >= bits) ? '0 : bits - hits;
    assign rem_shift = {rem_reg, 1'b0};
    assign fits      = rem_shift >= {1'b0, bits_reg};
    assign rem_next  = fits ? COUNT_WIDTH'(rem_shift - {1'b0, bits_reg})
                            : COUNT_WIDTH'(rem_shift);
    assign quo_next  = {quo_reg[RATE_FRAC_BITS-2:0], fits};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(RATE_FRAC_BITS);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= errs;
            bits_reg <= bits;
            quo_reg  <= '0;
            zero_reg <= (bits == '0);
            // all bits wrong: the fraction is 1.0, clamp to the top code
            sat_reg  <= (errs == bits);
        end else if (run_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_comb begin
        priority if (zero_reg) begin
            result = '0;
        end else if (sat_reg) begin
            result = '1;
        end else begin
            result = quo_reg;
        end
    end

    assign rate = 16'(result);
    assign done = done_reg;

endmodule

FILE: design/qwe_ctrl.sv
module qwe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  qwe_pkg::dp_status_t stat,
    output qwe_pkg::ctrl_cmd_t  cmd
);
    import qwe_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SAME_GO   = 3'd1;
    localparam logic [2:0] ST_SAME_WAIT = 3'd2;
    localparam logic [2:0] ST_DIFF_GO   = 3'd3;
    localparam logic [2:0] ST_DIFF_WAIT = 3'd4;
    localparam logic [2:0] ST_REPORT    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       ready;

    assign ready    = (state_reg == ST_IDLE) && stat.out_free;
    assign s_tready = ready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_tvalid && ready;
                if (cmd.accept && stat.close) begin
                    state_next = ST_SAME_GO;
                end
            end
            ST_SAME_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_SAME_WAIT;
            end
            ST_SAME_WAIT: begin
                if (stat.div_done) begin
                    cmd.cap_same = 1'b1;
                    state_next   = ST_DIFF_GO;
                end
            end
            ST_DIFF_GO: begin
                cmd.div_start    = 1'b1;
                cmd.div_sel_diff = 1'b1;
                state_next       = ST_DIFF_WAIT;
            end
            ST_DIFF_WAIT: begin
                cmd.div_sel_diff = 1'b1;
                if (stat.div_done) begin
                    cmd.cap_diff = 1'b1;
                    state_next   = ST_REPORT;
                end
            end
            ST_REPORT: begin
                // hold the report until the output slot frees up
                if (stat.out_free) begin
                    cmd.load_report = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/qwe_datapath.sv
module qwe_datapath #(
    parameter int COUNT_WIDTH    = qwe_pkg::COUNT_WIDTH_DEF,
    parameter int RATE_FRAC_BITS = qwe_pkg::RATE_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [qwe_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          cfg_we,
    input  logic [15:0]                   cfg_wdata,
    input  qwe_pkg::ctrl_cmd_t            cmd,
    output qwe_pkg::dp_status_t           stat,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [qwe_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tlast
);
    import qwe_pkg::*;

    localparam int CW    = COUNT_WIDTH;
    localparam int CMP_W = (CW > 16) ? CW : 16;

    logic [15:0] win_len_reg;

    logic [CW-1:0] det_reg, det_next;
    logic [CW-1:0] same_bits_reg, same_bits_next;
    logic [CW-1:0] same_match_reg, same_match_next;
    logic [CW-1:0] all_bits_reg, all_bits_next;
    logic [CW-1:0] diff_match_reg, diff_match_next;
    logic [CW-1:0] noclick_reg, noclick_next;
    logic [CW-1:0] double_reg, double_next;

    logic [CW-1:0] snap_same_bits_reg, snap_same_match_reg;
    logic [CW-1:0] snap_diff_bits_reg, snap_diff_match_reg;
    logic [CW-1:0] snap_noclick_reg, snap_double_reg;
    logic [2:0]    snap_code_reg;
    logic [15:0]   rate_same_reg;

    logic          out_valid_reg;
    logic          out_last_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic        alice_bit, alice_basis, bob_basis;
    logic [2:0]  bob_value;
    logic        is_ctrl, is_noclick, is_double, is_bit, is_match, same_basis;
    logic [2:0]  slot_code;
    logic        close;
    logic [CW-1:0] diff_bits_next;

    logic          div_done;
    logic [15:0]   div_rate;
    logic [CW-1:0] div_bits, div_matches;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v, input logic en);
        sat_inc = (en && (v != '1)) ? v + 1'b1 : v;
    endfunction

    assign alice_bit   = s_tdata[0];
    assign bob_value   = s_tdata[3:1];
    assign alice_basis = s_tdata[4];
    assign bob_basis   = s_tdata[5];

    assign is_ctrl    = (bob_value == CODE_CONTROL);
    assign is_noclick = (bob_value == CODE_NOCLICK);
    assign is_double  = (bob_value == CODE_DOUBLE);
    assign is_bit     = !is_ctrl && !is_noclick && !is_double;
    // values above one never equal the sender bit
    assign is_match   = (bob_value == {2'b00, alice_bit});
    assign same_basis = (alice_basis == bob_basis);

    always_comb begin
        priority if (is_ctrl) begin
            slot_code = CODE_CONTROL;
        end else if (is_noclick) begin
            slot_code = CODE_NOCLICK;
        end else if (is_double) begin
            slot_code = CODE_DOUBLE;
        end else if (is_match) begin
            slot_code = CODE_MATCH;
        end else begin
            slot_code = CODE_ERROR;
        end
    end

    assign det_next        = sat_inc(det_reg, is_bit);
    assign all_bits_next   = sat_inc(all_bits_reg, is_bit);
    assign same_bits_next  = sat_inc(same_bits_reg, is_bit && same_basis);
    assign same_match_next = sat_inc(same_match_reg, is_bit && same_basis && is_match);
    assign diff_match_next = sat_inc(diff_match_reg, is_bit && !same_basis && is_match);
    assign noclick_next    = sat_inc(noclick_reg, is_noclick);
    assign double_next     = sat_inc(double_reg, is_double);
    assign diff_bits_next  = (all_bits_next >= same_bits_next)
                             ? all_bits_next - same_bits_next : '0;

    assign close = !is_ctrl && (CMP_W'(det_next) >= CMP_W'(win_len_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg <= WIN_LEN_RESET;
        end else if (cfg_we) begin
            win_len_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            det_reg        <= '0;
            same_bits_reg  <= '0;
            same_match_reg <= '0;
            all_bits_reg   <= '0;
            diff_match_reg <= '0;
            noclick_reg    <= '0;
            double_reg     <= '0;
        end else if (cmd.accept) begin
            if (close) begin
                det_reg        <= '0;
                same_bits_reg  <= '0;
                same_match_reg <= '0;
                all_bits_reg   <= '0;
                diff_match_reg <= '0;
                noclick_reg    <= '0;
                double_reg     <= '0;
            end else begin
                det_reg        <= det_next;
                same_bits_reg  <= same_bits_next;
                same_match_reg <= same_match_next;
                all_bits_reg   <= all_bits_next;
                diff_match_reg <= diff_match_next;
                noclick_reg    <= noclick_next;
                double_reg     <= double_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && close) begin
            snap_same_bits_reg  <= same_bits_next;
            snap_same_match_reg <= same_match_next;
            snap_diff_bits_reg  <= diff_bits_next;
            snap_diff_match_reg <= diff_match_next;
            snap_noclick_reg    <= noclick_next;
            snap_double_reg     <= double_next;
            snap_code_reg       <= slot_code;
        end
        if (cmd.cap_same) begin
            rate_same_reg <= div_rate;
        end
    end

    assign div_bits    = cmd.div_sel_diff ? snap_diff_bits_reg : snap_same_bits_reg;
    assign div_matches = cmd.div_sel_diff ? snap_diff_match_reg : snap_same_match_reg;

    qwe_divider #(
        .COUNT_WIDTH    (COUNT_WIDTH),
        .RATE_FRAC_BITS (RATE_FRAC_BITS)
    ) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .bits    (div_bits),
        .hits    (div_matches),
        .done    (div_done),
        .rate    (div_rate)
    );

    // output slot: plain codes load at accept, reports once both rates are in
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((cmd.accept && !close) || cmd.load_report) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    logic [15:0] rate_diff_reg;

    always_ff @(posedge aclk) begin
        if (cmd.cap_diff) begin
            rate_diff_reg <= div_rate;
        end
        if (cmd.accept && !close) begin
            out_last_reg <= 1'b0;
            out_data_reg <= {5'b0, 128'b0, slot_code};
        end else if (cmd.load_report) begin
            out_last_reg <= 1'b1;
            out_data_reg <= {5'b0, rate_diff_reg, rate_same_reg,
                             16'(snap_double_reg), 16'(snap_noclick_reg),
                             16'(snap_diff_match_reg), 16'(snap_diff_bits_reg),
                             16'(snap_same_match_reg), 16'(snap_same_bits_reg),
                             snap_code_reg};
        end
    end

    assign stat.close    = close;
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: design/qber_window_estimator.sv
// Channel   Dir  Handshake           Payload
// s_axis    in   s_tvalid/s_tready   s_tdata: alice_bit, bob_value, alice_basis, bob_basis
// m_axis    out  m_tvalid/m_tready   m_tdata: slot code and window report; m_tlast: window_done
// cfg       in   cfg_we              cfg_wdata: window_length
//
// An item that does not close a window is handled at one item per clock while m_tready stays high.
// An item that closes a window holds off further input until its report is loaded: both error
// rates come out of one shared restoring divider, one quotient bit per cycle.
// Reset clears the counters and sets window_length to 1024.
// The output register holds one item; input is taken while that item leaves.
module qber_window_estimator #(
    parameter int COUNT_WIDTH    = qwe_pkg::COUNT_WIDTH_DEF,
    parameter int RATE_FRAC_BITS = qwe_pkg::RATE_FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [0] alice_bit, [3:1] bob_value, [4] alice_basis, [5] bob_basis, [7:6] zero
    input  logic [qwe_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [2:0] slot_code, [18:3] same_basis_bits, [34:19] same_basis_matches,
    // [50:35] diff_basis_bits, [66:51] diff_basis_matches, [82:67] no_click_total,
    // [98:83] double_click_total, [114:99] error_rate_same,
    // [130:115] error_rate_diff, [135:131] zero
    output logic [qwe_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tlast,
    input  logic                         cfg_we,
    input  logic [15:0]                  cfg_wdata
);
    import qwe_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    qwe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    qwe_datapath #(
        .COUNT_WIDTH    (COUNT_WIDTH),
        .RATE_FRAC_BITS (RATE_FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> (!m_tvalid || m_tready))
        else $error("item accepted while output slot is blocked");

    a_close_not_control: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[2:0] != CODE_CONTROL))
        else $error("control item closed a window");

    a_report_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[REPORT_HI:REPORT_LO] == '0))
        else $error("report fields set outside a window close");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && stat.close) |=> !s_tready)
        else $error("input taken during window report");

endmodule
